// ----- src/tks_pkg.sv -----
package tks_pkg;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_WAIT,
    ST_SORT_CMP,
    ST_THR_RD,
    ST_THR_WAIT,
    ST_PUSH_OUT,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_OUT,
    ST_EMPTY_OUT
  } state_e;

  localparam logic [31:0] KeyAllOnes = 32'hFFFF_FFFF;
  localparam int unsigned LaneGroup = 32;

  // one buffered item
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] aux;
    logic [31:0] tag;
  } entry_t;

  function automatic logic item_before(entry_t a, entry_t b);
    if (a.key != b.key) return a.key < b.key;
    return a.tag < b.tag;
  endfunction

endpackage

// ----- src/tks_in_if.sv -----
interface tks_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] sort_key;
  logic [31:0] aux_value;
  logic [31:0] item_tag;
  modport source (output valid, opcode, sort_key, aux_value, item_tag, input ready);
  modport sink (input valid, opcode, sort_key, aux_value, item_tag, output ready);
endinterface

// ----- src/tks_out_if.sv -----
interface tks_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_key;
  logic [31:0] out_aux;
  logic [31:0] out_tag;
  logic        compacted;
  logic [7:0]  kept_items;
  logic        last_item;
  modport source (output valid, out_key, out_aux, out_tag, compacted, kept_items, last_item,
                  input ready);
  modport sink (input valid, out_key, out_aux, out_tag, compacted, kept_items, last_item,
                output ready);
endinterface

// ----- src/tks_ram.sv -----
module tks_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/top_k_smallest_selector.sv -----
// Top-k smallest selector.
// Input channel (in_if): opcode push, finalize or clear with key, aux and tag.
// Output channel (out_if): one result per push (threshold, compacted flag,
// fill count); finalize gives the kept items in ascending (key, tag) order,
// the last one marked, or one all-zero marked result on an empty buffer.
// Clear gives no result. keep_count is written through cfg_we_i/cfg_wdata_i.
// One item is worked at a time; ready is high only in idle with no result held.
// A push that does not fill the buffer goes through the sort-read, threshold-read
// and threshold-wait states to the result state. A filling push sorts the buffer
// by insertion in one item memory with one read port: each shift step is a
// read-wait state then a compare state, and each placed item passes through
// the sort-read, wait and compare states.
// Finalize sorts the same way, then emits the kept items one at a time.
// The output register holds a result until taken; a stalled receiver only
// halts the block. Reset empties the buffer, sets the threshold to all
// ones and keep_count to 10; the memory needs no clearing pass.
module top_k_smallest_selector
  import tks_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 128,
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  tks_in_if.sink     in_if,
  tks_out_if.source  out_if
);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned KLim = (MAX_KEEP < BUFFER_DEPTH / 2) ? MAX_KEEP : BUFFER_DEPTH / 2;

  state_e state_q, state_d;
  logic [6:0]    keep_q;
  logic [CW-1:0] fill_q, fill_d;
  logic [31:0]   thr_q, thr_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  entry_t        hold_q, hold_d;
  logic          is_fin_q, is_fin_d;
  logic          comp_q, comp_d;
  // output register
  entry_t        o_ent_q, o_ent_d;
  logic          o_valid_q, o_valid_d, o_comp_q, o_comp_d, o_last_q, o_last_d;
  logic [7:0]    o_kept_q, o_kept_d;
  // shift loop tracking
  logic          shifting;
  logic          in_shift_q;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  tks_ram #(.Width($bits(entry_t)), .Depth(BUFFER_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  // effective keep count and capacity
  logic [6:0]    k_eff;
  logic [CW-1:0] cap;
  logic [8:0]    cap_raw;
  always_comb begin
    k_eff = keep_q;
    if (k_eff == 7'd0) k_eff = 7'd1;
    if (32'(k_eff) > KLim) k_eff = 7'(KLim);
    cap_raw = ({1'b0, k_eff, 1'b0} + 9'(LaneGroup - 1)) & ~9'(LaneGroup - 1);
    cap = (32'(cap_raw) > BUFFER_DEPTH) ? CW'(BUFFER_DEPTH) : CW'(cap_raw);
  end

  entry_t in_ent;
  assign in_ent = '{key: in_if.sort_key, aux: in_if.aux_value, tag: in_if.item_tag};
  logic [CW-1:0] kept_n;
  assign kept_n = (fill_q > CW'(k_eff)) ? CW'(k_eff) : fill_q;

  assign in_if.ready = (state_q == ST_IDLE) && !o_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid && in_if.ready) begin
        unique case (opcode_e'(in_if.opcode))
          OP_PUSH:     state_d = ST_SORT_RD;
          OP_FINALIZE: state_d = ST_SORT_RD;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_SORT_RD:   state_d = (i_q >= fill_q) ? (is_fin_q ? ST_EMIT_RD : ST_THR_RD) :
                              ST_SORT_WAIT;
      ST_SORT_WAIT: state_d = ST_SORT_CMP;
      ST_SORT_CMP:  state_d = (j_q != '0 && item_before(hold_q, rdata)) ? ST_SORT_WAIT :
                              ST_SORT_RD;
      ST_THR_RD:    state_d = ST_THR_WAIT;
      ST_THR_WAIT:  state_d = ST_PUSH_OUT;
      ST_PUSH_OUT:  if (!o_valid_q) state_d = ST_IDLE;
      ST_EMIT_RD:   state_d = (fill_q == '0) ? ST_EMPTY_OUT : ST_EMIT_WAIT;
      ST_EMIT_WAIT: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT:  if (!o_valid_q) state_d = (i_q + 1'b1 >= fill_q) ? ST_IDLE : ST_EMIT_RD;
      ST_EMPTY_OUT: if (!o_valid_q) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_d = fill_q; thr_d = thr_q; i_d = i_q; j_d = j_q; hold_d = hold_q;
    is_fin_d = is_fin_q; comp_d = comp_q;
    o_ent_d = o_ent_q; o_comp_d = o_comp_q; o_last_d = o_last_q; o_kept_d = o_kept_q;
    o_valid_d = o_valid_q && !out_if.ready;
    we = 1'b0; waddr = '0; wdata = in_ent; raddr = '0;
    unique case (state_q)
      ST_IDLE: if (in_if.valid && in_if.ready) begin
        i_d = CW'(1);
        j_d = CW'(1);
        unique case (opcode_e'(in_if.opcode))
          OP_PUSH: begin
            is_fin_d = 1'b0;
            comp_d = 1'b0;
            if (fill_q < CW'(BUFFER_DEPTH)) begin
              we = 1'b1; waddr = AW'(fill_q);
              fill_d = fill_q + 1'b1;
            end
            // no sort unless the buffer reached capacity
            if (((fill_q < CW'(BUFFER_DEPTH)) ? fill_q + 1'b1 : fill_q) >= cap) comp_d = 1'b1;
            else i_d = CW'(BUFFER_DEPTH);
          end
          OP_FINALIZE: is_fin_d = 1'b1;
          OP_CLEAR: begin fill_d = '0; thr_d = KeyAllOnes; end
          default: ;
        endcase
      end
      // read the item to insert, or stop
      ST_SORT_RD: begin
        raddr = AW'(i_q);
        if (i_q >= fill_q) i_d = '0;
      end
      // load the item to insert; after a shift read the next lower entry
      ST_SORT_WAIT: begin
        if (in_shift_q) raddr = AW'(j_q - 1'b1);
        else begin
          hold_d = rdata;
          j_d = i_q;
          raddr = AW'(i_q - 1'b1);
        end
      end
      // compare hold with entry j-1; shift it up or drop hold in place
      ST_SORT_CMP: begin
        we = 1'b1;
        if (j_q != '0 && item_before(hold_q, rdata)) begin
          waddr = AW'(j_q); wdata = rdata;
          j_d = j_q - 1'b1;
        end else begin
          waddr = AW'(j_q); wdata = hold_q;
          i_d = i_q + 1'b1;
        end
      end
      ST_THR_RD: begin
        if (comp_q) fill_d = kept_n;
      end
      ST_THR_WAIT: raddr = AW'(fill_q - 1'b1);
      ST_PUSH_OUT: if (!o_valid_q) begin
        if (comp_q) thr_d = (fill_q != '0) ? rdata.key : KeyAllOnes;
        o_valid_d = 1'b1;
        o_ent_d = '{key: comp_q ? ((fill_q != '0) ? rdata.key : KeyAllOnes) : thr_q,
                    aux: '0, tag: '0};
        o_comp_d = comp_q;
        o_kept_d = 8'(fill_q);
        o_last_d = 1'b1;
      end
      ST_EMIT_RD: begin
        if (i_q == '0) fill_d = kept_n;
        raddr = AW'(i_q);
      end
      ST_EMIT_WAIT: raddr = AW'(i_q);
      ST_EMIT_OUT: begin
        raddr = AW'(i_q);
        if (!o_valid_q) begin
          o_valid_d = 1'b1;
          o_ent_d = rdata;
          o_comp_d = 1'b0;
          o_kept_d = '0;
          o_last_d = (i_q + 1'b1 >= fill_q);
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 >= fill_q) begin fill_d = '0; thr_d = KeyAllOnes; end
        end
      end
      ST_EMPTY_OUT: if (!o_valid_q) begin
        o_valid_d = 1'b1;
        o_ent_d = '0;
        o_comp_d = 1'b0;
        o_kept_d = '0;
        o_last_d = 1'b1;
        thr_d = KeyAllOnes;
      end
      default: ;
    endcase
  end

  // shift loop: the next compare needs the entry below j while holding the item
  assign shifting = (state_q == ST_SORT_CMP) && (state_d == ST_SORT_WAIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      keep_q    <= 7'd10;
      fill_q    <= '0;
      thr_q     <= KeyAllOnes;
      i_q       <= '0;
      j_q       <= '0;
      is_fin_q  <= 1'b0;
      comp_q    <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) keep_q <= cfg_wdata_i;
      fill_q    <= fill_d;
      thr_q     <= thr_d;
      i_q       <= i_d;
      j_q       <= j_d;
      is_fin_q  <= is_fin_d;
      comp_q    <= comp_d;
      o_valid_q <= o_valid_d;
    end
  end

  // wait state after a shift re-reads entry j-1 (j already decremented)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_shift_q <= 1'b0;
    else in_shift_q <= shifting;
  end

  always_ff @(posedge clk_i) begin
    hold_q   <= (in_shift_q && state_q == ST_SORT_WAIT) ? hold_q : hold_d;
    o_ent_q  <= o_ent_d;
    o_comp_q <= o_comp_d;
    o_last_q <= o_last_d;
    o_kept_q <= o_kept_d;
  end

  assign out_if.valid      = o_valid_q;
  assign out_if.out_key    = o_ent_q.key;
  assign out_if.out_aux    = o_ent_q.aux;
  assign out_if.out_tag    = o_ent_q.tag;
  assign out_if.compacted  = o_comp_q;
  assign out_if.kept_items = o_kept_q;
  assign out_if.last_item  = o_last_q;
endmodule

// ----- dv/tb_top_k_smallest_selector.sv -----
module tb_top_k_smallest_selector;
  import tks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 128;
  localparam int unsigned MaxKeep = 64;
  localparam int unsigned WatchLimit = 200000;

  // one expected result
  typedef struct packed {
    logic [31:0] out_key;
    logic [31:0] out_aux;
    logic [31:0] out_tag;
    logic        compacted;
    logic [7:0]  kept_items;
    logic        last_item;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  tks_in_if in_if ();
  tks_out_if out_if ();

  top_k_smallest_selector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  entry_t      held_q[$];
  logic [31:0] threshold = KeyAllOnes;
  logic [6:0]  keep_reg = 7'd10;
  result_t     pending_q[$];

  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          rx_noidle = 1'b0;
  bit          tx_noidle = 1'b0;
  bit          rx_hold = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_PUSH;
    in_if.sort_key = '0;
    in_if.aux_value = '0;
    in_if.item_tag = '0;
    out_if.ready = 1'b0;
  end

  function automatic int unsigned keep_eff();
    int unsigned k;
    k = keep_reg;
    if (k < 1) k = 1;
    if (k > MaxKeep) k = MaxKeep;
    if (k > Depth / 2) k = Depth / 2;
    return k;
  endfunction

  function automatic int unsigned cap_of(int unsigned k);
    int unsigned c;
    c = ((2 * k + LaneGroup - 1) / LaneGroup) * LaneGroup;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  // stable sort by (key, tag), keep the k smallest
  function automatic void trim_held(int unsigned k);
    entry_t e;
    int j;
    for (int i = 1; i < held_q.size(); i++) begin
      e = held_q[i];
      j = i;
      while (j > 0 && (e.key < held_q[j-1].key ||
                       (e.key == held_q[j-1].key && e.tag < held_q[j-1].tag))) begin
        held_q[j] = held_q[j-1];
        j--;
      end
      held_q[j] = e;
    end
    while (held_q.size() > k) void'(held_q.pop_back());
  endfunction

  function automatic void predict_step(opcode_e op, entry_t e);
    result_t r;
    int unsigned k;
    int unsigned n;
    k = keep_eff();
    r = '0;
    case (op)
      OP_PUSH: begin
        if (held_q.size() < Depth) held_q.push_back(e);
        if (held_q.size() >= cap_of(k)) begin
          trim_held(k);
          threshold = (held_q.size() > 0) ? held_q[held_q.size()-1].key : KeyAllOnes;
          r.compacted = 1'b1;
        end
        r.out_key = threshold;
        r.kept_items = 8'(held_q.size());
        r.last_item = 1'b1;
        pending_q.push_back(r);
      end
      OP_FINALIZE: begin
        trim_held(k);
        n = held_q.size();
        if (n == 0) begin
          r.last_item = 1'b1;
          pending_q.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
          r = '0;
          r.out_key = held_q[i].key;
          r.out_aux = held_q[i].aux;
          r.out_tag = held_q[i].tag;
          r.last_item = (i + 1 == n);
          pending_q.push_back(r);
        end
        held_q.delete();
        threshold = KeyAllOnes;
      end
      OP_CLEAR: begin
        held_q.delete();
        threshold = KeyAllOnes;
      end
      default: ;
    endcase
  endfunction

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    if (rx_hold) out_if.ready <= 1'b0;
    else if (rx_noidle) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(99) >= 10);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result key=%h", out_if.out_key);
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_if.out_key !== exp_r.out_key) begin
          $error("out_key exp %h got %h", exp_r.out_key, out_if.out_key); fail_cnt++;
        end
        if (out_if.out_aux !== exp_r.out_aux) begin
          $error("out_aux exp %h got %h", exp_r.out_aux, out_if.out_aux); fail_cnt++;
        end
        if (out_if.out_tag !== exp_r.out_tag) begin
          $error("out_tag exp %h got %h", exp_r.out_tag, out_if.out_tag); fail_cnt++;
        end
        if (out_if.compacted !== exp_r.compacted) begin
          $error("compacted exp %b got %b", exp_r.compacted, out_if.compacted); fail_cnt++;
        end
        if (out_if.kept_items !== exp_r.kept_items) begin
          $error("kept_items exp %0d got %0d", exp_r.kept_items, out_if.kept_items);
          fail_cnt++;
        end
        if (out_if.last_item !== exp_r.last_item) begin
          $error("last_item exp %b got %b", exp_r.last_item, out_if.last_item); fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[top_k_smallest_selector] ERROR");
      $finish;
    end
  end

  // send one item, predicting at the transfer; valid stays up for the next item
  task automatic send_item(opcode_e op, logic [31:0] key, logic [31:0] aux,
                           logic [31:0] tag);
    entry_t e;
    e.key = key;
    e.aux = aux;
    e.tag = tag;
    while (!tx_noidle && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.sort_key <= key;
    in_if.aux_value <= aux;
    in_if.item_tag <= tag;
    do @(posedge clk_i); while (!in_if.ready);
    predict_step(op, e);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // a clear or idle opcode may still be in flight
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_keep(logic [6:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keep_reg = v;
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom();
      2: return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return 32'h3F80_0000 + $urandom_range(255);
    endcase
  endfunction

  task automatic push_rand();
    send_item(OP_PUSH, rand_key(), $urandom(), $urandom_range(7) == 0 ? $urandom_range(3)
                                                                      : $urandom());
  endtask

  // extremes of the fields, every opcode, empty finalize, ties
  task automatic test_directed();
    send_item(OP_FINALIZE, '0, '0, '0);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUSH, '0, '0, '0);
    send_item(OP_PUSH, 32'd5, 32'h1234_5678, 32'd9);
    send_item(OP_PUSH, 32'd5, 32'hAAAA_AAAA, 32'd3);
    send_item(OP_PUSH, 32'd5, 32'h5555_5555, 32'd3);
    send_item(OP_NONE, 32'd1, 32'd1, 32'd1);
    send_item(OP_FINALIZE, '0, '0, '0);
    send_item(OP_PUSH, 32'd7, 32'd7, 32'd7);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_FINALIZE, '0, '0, '0);
    write_keep(7'd0);
    repeat (33) send_item(OP_PUSH, $urandom_range(40), $urandom(), $urandom_range(40));
    send_item(OP_FINALIZE, '0, '0, '0);
  endtask

  // keep count lowered with items held
  task automatic test_keep_lowered();
    write_keep(7'd40);
    repeat (20) push_rand();
    write_keep(7'd3);
    repeat (3) push_rand();
    send_item(OP_FINALIZE, '0, '0, '0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_keep(7'd10);
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (30) push_rand();
    join
    send_item(OP_FINALIZE, '0, '0, '0);
    drain();
  endtask

  task automatic test_random(int unsigned n, logic [6:0] keep);
    int unsigned sel;
    write_keep(keep);
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 85) push_rand();
      else if (sel < 93) send_item(OP_FINALIZE, $urandom(), $urandom(), $urandom());
      else if (sel < 97) send_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
      else send_item(OP_NONE, $urandom(), $urandom(), $urandom());
    end
    send_item(OP_FINALIZE, '0, '0, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_keep_lowered();
    test_backpressure();
    test_random(40, 7'd127);
    test_random(40, 7'd1);
    rx_noidle = 1'b1;
    tx_noidle = 1'b1;
    test_random(40, 7'd64);
    rx_noidle = 1'b0;
    tx_noidle = 1'b0;
    test_random(40, 7'($urandom_range(2, 20)));
    drain();
    if (fail_cnt == 0) $display("[top_k_smallest_selector] OK");
    else $display("[top_k_smallest_selector] ERROR");
    $finish;
  end

endmodule
